### hdl/stlm_pkg.sv
// ----------------------------------------------------------------------------
// stlm_pkg
// Types and constants shared by the sorted timer list manager.
// ----------------------------------------------------------------------------
package stlm_pkg;

  localparam int unsigned SLOT_W = 4;

  localparam logic [31:0] SENTINEL_DEADLINE = 32'hffff_ffff;

  localparam logic [1:0] SLOT_FREE      = 2'd0;
  localparam logic [1:0] SLOT_ALLOCATED = 2'd1;
  localparam logic [1:0] SLOT_RUNNING   = 2'd2;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_BIND  = 3'd2;
  localparam logic [2:0] OP_ARM   = 3'd3;
  localparam logic [2:0] OP_FREE  = 3'd4;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_TASK   = 2'd1;
  localparam logic [1:0] KIND_ALLOC  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // Write and read controls from the sequencer to the slot store.
  typedef struct packed {
    logic              link_we;
    logic [SLOT_W-1:0] link_wa;
    logic [SLOT_W-1:0] link_wd;
    logic              link2_we;
    logic [SLOT_W-1:0] link2_wa;
    logic [SLOT_W-1:0] link2_wd;
    logic              dl_we;
    logic [SLOT_W-1:0] dl_wa;
    logic [31:0]       dl_wd;
    logic              bind_we;
    logic [SLOT_W-1:0] bind_wa;
    logic [7:0]        bind_sink;
    logic [7:0]        bind_payload;
    logic              st_we;
    logic [SLOT_W-1:0] st_wa;
    logic [1:0]        st_wd;
    logic [SLOT_W-1:0] rd_idx;
  } store_ctl_t;

endpackage

### hdl/stlm_if.sv
// ----------------------------------------------------------------------------
// stlm_cmd_if / stlm_res_if
// Valid/ready channels for command requests and result requests.
// ----------------------------------------------------------------------------
interface stlm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  timer_slot;
  logic [31:0] delay;
  logic [7:0]  sink_id;
  logic [7:0]  payload;

  modport source (output valid, op, timer_slot, delay, sink_id, payload, input ready);
  modport sink   (input valid, op, timer_slot, delay, sink_id, payload, output ready);
endinterface

interface stlm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] slot_out;
  logic [7:0] sink_out;
  logic [7:0] payload_out;
  logic       ok;
  logic       last;

  modport source (output valid, kind, slot_out, sink_out, payload_out, ok, last,
                  input ready);
  modport sink   (input valid, kind, slot_out, sink_out, payload_out, ok, last,
                  output ready);
endinterface

### hdl/stlm_alu.sv
// ----------------------------------------------------------------------------
// stlm_alu
// Shared 32-bit adder and less-or-equal comparator used by the tick and arm steps.
// ----------------------------------------------------------------------------
module stlm_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [32:0] sum,
  output logic        le
);
  assign sum = {1'b0, a} + {1'b0, b};
  assign le  = (a <= b);
endmodule

### hdl/stlm_slot_store.sv
// ----------------------------------------------------------------------------
// stlm_slot_store
// Per-slot deadline, link, sink, payload and state registers.
// ----------------------------------------------------------------------------
module stlm_slot_store #(
  parameter int LIM = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stlm_pkg::store_ctl_t  ctl,
  output logic [31:0]           rd_deadline,
  output logic [3:0]            rd_link,
  output logic [7:0]            rd_sink,
  output logic [7:0]            rd_payload,
  output logic [LIM-1:0][1:0]   slot_state
);
  localparam int IW = $clog2(LIM);

  logic [31:0] deadline_r [LIM];
  logic [3:0]  link_r     [LIM];
  logic [7:0]  sink_r     [LIM];
  logic [7:0]  payload_r  [LIM];
  logic [LIM-1:0][1:0] state_r;

  always_ff @(posedge clk) begin
    if (ctl.dl_we) begin
      deadline_r[ctl.dl_wa[IW-1:0]] <= ctl.dl_wd;
    end
    if (ctl.link_we) begin
      link_r[ctl.link_wa[IW-1:0]] <= ctl.link_wd;
    end
    if (ctl.link2_we) begin
      link_r[ctl.link2_wa[IW-1:0]] <= ctl.link2_wd;
    end
    if (ctl.bind_we) begin
      sink_r[ctl.bind_wa[IW-1:0]]    <= ctl.bind_sink;
      payload_r[ctl.bind_wa[IW-1:0]] <= ctl.bind_payload;
    end
  end

  // Slot 0 is the sentinel and is never armed, so its deadline is fixed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LIM; i++) begin
        state_r[i] <= (i == 0) ? stlm_pkg::SLOT_RUNNING : stlm_pkg::SLOT_FREE;
      end
    end else if (ctl.st_we) begin
      state_r[ctl.st_wa[IW-1:0]] <= ctl.st_wd;
    end
  end

  assign rd_deadline = (ctl.rd_idx == '0) ? stlm_pkg::SENTINEL_DEADLINE
                                          : deadline_r[ctl.rd_idx[IW-1:0]];
  assign rd_link     = link_r[ctl.rd_idx[IW-1:0]];
  assign rd_sink     = sink_r[ctl.rd_idx[IW-1:0]];
  assign rd_payload  = payload_r[ctl.rd_idx[IW-1:0]];
  assign slot_state  = state_r;
endmodule

### hdl/sorted_timer_list_manager.sv
// ----------------------------------------------------------------------------
// sorted_timer_list_manager
// One-shot timer pool kept as a deadline-sorted list, driven by commands.
// ----------------------------------------------------------------------------
// Channel    Dir   Handshake      Carries
// in_chan    in    valid/ready    op, timer_slot, delay, sink_id, payload
// out_chan   out   valid/ready    kind, slot_out, sink_out, payload_out, ok, last
// cfg_*      in    write enable   task_timer_slot
//
// Allocate, bind, free, unknown ops and arms of an out-of-range slot go straight
// to the result step; an arm of a slot that is not allocated fails after a state
// check. A successful arm walks the list to its place. A tick that expires timers
// walks the expired entries and delivers each, with any task switch result after
// the deliveries. The tick and arm steps use the one shared adder and comparator.
// Reset is synchronous; a stalled result register holds the sequencer.
// ----------------------------------------------------------------------------
module sorted_timer_list_manager #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stlm_cmd_if.sink   in_chan,
  stlm_res_if.source out_chan,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);
  localparam int LIM = (TIMER_SLOTS < 16) ? TIMER_SLOTS : 16;
  localparam int IW  = $clog2(LIM);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TICK  = 8'b0000_0010,
    S_TCHK  = 8'b0000_0100,
    S_TWALK = 8'b0000_1000,
    S_TEND  = 8'b0001_0000,
    S_ARM0  = 8'b0010_0000,
    S_ARM1  = 8'b0100_0000,
    S_ONE   = 8'b1000_0000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [7:0]  sink_r, sink_nxt, pay_r, pay_nxt;
  logic [31:0] tick_r, tick_nxt, nd_r, nd_nxt, dl_r, dl_nxt;
  logic [3:0]  head_r, head_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic        first_r, first_nxt, ts_r, ts_nxt, ok_r, ok_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [3:0]  pend_slot_r, pend_slot_nxt;
  logic [7:0]  pend_sink_r, pend_sink_nxt, pend_pay_r, pend_pay_nxt;
  logic [3:0]  task_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [7:0]  out_sink_r, out_sink_nxt, out_pay_r, out_pay_nxt;
  logic        out_ok_r, out_ok_nxt, out_last_r, out_last_nxt;

  stlm_pkg::store_ctl_t ctl;
  logic [31:0] rd_deadline;
  logic [3:0]  rd_link;
  logic [7:0]  rd_sink, rd_payload;
  logic [LIM-1:0][1:0] slot_state;

  logic [31:0] alu_a, alu_b;
  logic [32:0] alu_sum;
  logic        alu_le;

  logic        in_acc, can_push, in_range, found;
  logic [3:0]  found_idx;
  logic [1:0]  cur_state;

  stlm_alu u_alu (.a(alu_a), .b(alu_b), .sum(alu_sum), .le(alu_le));

  stlm_slot_store #(.LIM(LIM)) u_store (
    .clk, .rst_n, .ctl, .rd_deadline, .rd_link, .rd_sink, .rd_payload, .slot_state
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign can_push      = !out_valid_r || out_chan.ready;
  assign in_range      = (32'(slot_r) < 32'(TIMER_SLOTS));
  assign cur_state     = slot_state[slot_r[IW-1:0]];

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = LIM - 1; i >= 0; i--) begin
      if (slot_state[i] == stlm_pkg::SLOT_FREE) begin
        found     = 1'b1;
        found_idx = 4'(i);
      end
    end
  end

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_TICK:  begin alu_a = tick_r;  alu_b = 32'd1;       end
      S_TCHK:  begin alu_a = nd_r;    alu_b = tick_r;      end
      S_TWALK: begin alu_a = rd_deadline; alu_b = tick_r;  end
      S_ARM0:  begin alu_a = delay_r; alu_b = tick_r;      end
      S_ARM1:  begin alu_a = dl_r;    alu_b = rd_deadline; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    delay_nxt     = delay_r;
    sink_nxt      = sink_r;
    pay_nxt       = pay_r;
    tick_nxt      = tick_r;
    nd_nxt        = nd_r;
    dl_nxt        = dl_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    ts_nxt        = ts_r;
    ok_nxt        = ok_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_sink_nxt = pend_sink_r;
    pend_pay_nxt  = pend_pay_r;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_sink_nxt  = out_sink_r;
    out_pay_nxt   = out_pay_r;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;

    ctl        = '0;
    ctl.rd_idx = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_chan.op;
          slot_nxt  = in_chan.timer_slot;
          delay_nxt = in_chan.delay;
          sink_nxt  = in_chan.sink_id;
          pay_nxt   = in_chan.payload;
          case (in_chan.op)
            stlm_pkg::OP_TICK: state_nxt = S_TICK;
            stlm_pkg::OP_ARM: begin
              if (32'(in_chan.timer_slot) < 32'(TIMER_SLOTS)) begin
                state_nxt = S_ARM0;
              end else begin
                ok_nxt    = 1'b0;
                state_nxt = S_ONE;
              end
            end
            default: state_nxt = S_ONE;
          endcase
        end
      end

      S_TICK: begin
        // The counter stops one below the sentinel deadline.
        tick_nxt  = (alu_sum[31:0] == stlm_pkg::SENTINEL_DEADLINE) ? tick_r
                                                                   : alu_sum[31:0];
        state_nxt = S_TCHK;
      end

      S_TCHK: begin
        if (alu_le) begin
          cur_nxt   = head_r;
          ts_nxt    = 1'b0;
          state_nxt = S_TWALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_TWALK: begin
        if (!alu_le) begin
          head_nxt  = cur_r;
          nd_nxt    = rd_deadline;
          state_nxt = S_TEND;
        end else if ((task_r != '0) && (cur_r == task_r)) begin
          ctl.st_we = 1'b1;
          ctl.st_wa = cur_r;
          ctl.st_wd = stlm_pkg::SLOT_ALLOCATED;
          ts_nxt    = 1'b1;
          cur_nxt   = rd_link;
        end else if (!pend_v_r || can_push) begin
          // A delivery is held in the pending register so the final one can carry last.
          ctl.st_we = 1'b1;
          ctl.st_wa = cur_r;
          ctl.st_wd = stlm_pkg::SLOT_ALLOCATED;
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = stlm_pkg::KIND_EXPIRY;
            out_slot_nxt  = pend_slot_r;
            out_sink_nxt  = pend_sink_r;
            out_pay_nxt   = pend_pay_r;
            out_ok_nxt    = 1'b1;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = cur_r;
          pend_sink_nxt = rd_sink;
          pend_pay_nxt  = rd_payload;
          cur_nxt       = rd_link;
        end
      end

      S_TEND: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_sink_nxt  = '0;
          out_pay_nxt   = '0;
          out_ok_nxt    = 1'b1;
          if (pend_v_r) begin
            out_kind_nxt = stlm_pkg::KIND_EXPIRY;
            out_slot_nxt = pend_slot_r;
            out_sink_nxt = pend_sink_r;
            out_pay_nxt  = pend_pay_r;
            out_last_nxt = !ts_r;
            pend_v_nxt   = 1'b0;
            if (!ts_r) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_kind_nxt = stlm_pkg::KIND_TASK;
            out_slot_nxt = task_r;
            out_last_nxt = 1'b1;
            ts_nxt       = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end

      S_ARM0: begin
        if (cur_state != stlm_pkg::SLOT_ALLOCATED) begin
          ok_nxt    = 1'b0;
          state_nxt = S_ONE;
        end else begin
          dl_nxt     = alu_sum[32] ? stlm_pkg::SENTINEL_DEADLINE : alu_sum[31:0];
          ctl.dl_we  = 1'b1;
          ctl.dl_wa  = slot_r;
          ctl.dl_wd  = dl_nxt;
          ctl.st_we  = 1'b1;
          ctl.st_wa  = slot_r;
          ctl.st_wd  = stlm_pkg::SLOT_RUNNING;
          cur_nxt    = head_r;
          first_nxt  = 1'b1;
          ok_nxt     = 1'b1;
          state_nxt  = S_ARM1;
        end
      end

      S_ARM1: begin
        if (alu_le) begin
          ctl.link2_we = 1'b1;
          ctl.link2_wa = slot_r;
          ctl.link2_wd = cur_r;
          if (first_r) begin
            head_nxt = slot_r;
            nd_nxt   = dl_r;
          end else begin
            ctl.link_we = 1'b1;
            ctl.link_wa = prev_r;
            ctl.link_wd = slot_r;
          end
          state_nxt = S_ONE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = rd_link;
          first_nxt = 1'b0;
        end
      end

      S_ONE: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = stlm_pkg::KIND_STATUS;
          out_slot_nxt  = slot_r;
          out_sink_nxt  = '0;
          out_pay_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_ok_nxt    = 1'b0;
          case (op_r)
            stlm_pkg::OP_ALLOC: begin
              out_kind_nxt = stlm_pkg::KIND_ALLOC;
              out_slot_nxt = found ? found_idx : '0;
              out_ok_nxt   = found;
              ctl.st_we    = found;
              ctl.st_wa    = found_idx;
              ctl.st_wd    = stlm_pkg::SLOT_ALLOCATED;
            end
            stlm_pkg::OP_BIND: begin
              out_ok_nxt       = in_range;
              ctl.bind_we      = in_range;
              ctl.bind_wa      = slot_r;
              ctl.bind_sink    = sink_r;
              ctl.bind_payload = pay_r;
            end
            stlm_pkg::OP_ARM: out_ok_nxt = ok_r;
            stlm_pkg::OP_FREE: begin
              out_ok_nxt = in_range && (cur_state != stlm_pkg::SLOT_RUNNING);
              ctl.st_we  = out_ok_nxt;
              ctl.st_wa  = slot_r;
              ctl.st_wd  = stlm_pkg::SLOT_FREE;
            end
            default: out_ok_nxt = 1'b0;
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      nd_r        <= stlm_pkg::SENTINEL_DEADLINE;
      head_r      <= '0;
      ts_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      task_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      nd_r        <= nd_nxt;
      head_r      <= head_nxt;
      ts_r        <= ts_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        task_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    slot_r      <= slot_nxt;
    delay_r     <= delay_nxt;
    sink_r      <= sink_nxt;
    pay_r       <= pay_nxt;
    dl_r        <= dl_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    first_r     <= first_nxt;
    ok_r        <= ok_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_sink_r <= pend_sink_nxt;
    pend_pay_r  <= pend_pay_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_sink_r  <= out_sink_nxt;
    out_pay_r   <= out_pay_nxt;
    out_ok_r    <= out_ok_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.slot_out    = out_slot_r;
  assign out_chan.sink_out    = out_sink_r;
  assign out_chan.payload_out = out_pay_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.last        = out_last_r;
endmodule

### hdl/stlm_checker.sv
// ----------------------------------------------------------------------------
// stlm_checker
// Port-level checks on the timer list manager, bound to the top level.
// ----------------------------------------------------------------------------
module stlm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [3:0] out_slot_out,
  input logic [7:0] out_sink_out,
  input logic [7:0] out_payload_out,
  input logic       out_ok,
  input logic       out_last
);
  // A stalled result request keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_slot_out)
      && $stable(out_sink_out) && $stable(out_payload_out) && $stable(out_ok)
      && $stable(out_last))
    else $error("result changed while stalled");

  // While more results of a command are due, no new command is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("command taken before all results delivered");

  a_task_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == stlm_pkg::KIND_TASK |-> out_last && out_ok)
    else $error("task switch result is not the final one");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == stlm_pkg::KIND_ALLOC || out_kind == stlm_pkg::KIND_STATUS)
      |-> out_last && out_sink_out == '0 && out_payload_out == '0)
    else $error("reply or status malformed");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == stlm_pkg::KIND_EXPIRY |-> out_ok)
    else $error("expiry delivered without success");
endmodule

bind sorted_timer_list_manager stlm_checker u_stlm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_kind        (out_chan.kind),
  .out_slot_out    (out_chan.slot_out),
  .out_sink_out    (out_chan.sink_out),
  .out_payload_out (out_chan.payload_out),
  .out_ok          (out_chan.ok),
  .out_last        (out_chan.last)
);

### tb/stlm_test_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stlm_test_if
// Result record shared by the stimulus and checking code of the testbench.
// ----------------------------------------------------------------------------
package stlm_test_pkg;
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [7:0] sink;
    logic [7:0] payload;
    logic       ok;
    logic       last;
  } timer_result_t;
endpackage

### tb/sorted_timer_list_manager_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_timer_list_manager_test
// Drives command requests into the timer list manager and checks every result
// request against a behavioral model of the sorted list, with random gaps on
// both channels, a long result stall and task timer settings changed at idle.
// ----------------------------------------------------------------------------
module sorted_timer_list_manager_test;
  import stlm_pkg::*;
  import stlm_test_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  stlm_cmd_if in_chan ();
  stlm_res_if out_chan ();

  sorted_timer_list_manager i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Model state of the timer pool.
  logic [3:0]  m_task;
  logic [31:0] m_count, m_next;
  logic [3:0]  m_head;
  logic [3:0]  m_link [16];
  logic [31:0] m_dl [16];
  logic [1:0]  m_state [16];
  logic [7:0]  m_sink [16], m_pay [16];
  logic        m_bound [16];

  timer_result_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  int expiries_seen = 0;
  bit hold_off = 1'b0;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [7:0]  sink;
    logic [7:0]  pay;
  } timer_cmd_t;

  function automatic timer_result_t mk(logic [1:0] k, logic [3:0] s, logic [7:0] sk,
                                       logic [7:0] p, logic ok);
    timer_result_t r;
    r.kind = k; r.slot = s; r.sink = sk; r.payload = p; r.ok = ok; r.last = 1'b0;
    return r;
  endfunction

  function automatic string fmt(timer_result_t r);
    return $sformatf("kind %0d slot %0d sink %0d payload %0d ok %0d last %0d",
                     r.kind, r.slot, r.sink, r.payload, r.ok, r.last);
  endfunction

  function automatic void model_reset();
    m_task = 0; m_count = 0; m_next = SENTINEL_DEADLINE; m_head = 0;
    for (int i = 0; i < 16; i++) begin
      m_link[i] = 0; m_dl[i] = 0; m_state[i] = SLOT_FREE;
      m_sink[i] = 0; m_pay[i] = 0; m_bound[i] = 0;
    end
    m_dl[0] = SENTINEL_DEADLINE;
    m_state[0] = SLOT_RUNNING;
  endfunction

  function automatic logic arm_timer(logic [3:0] s, logic [31:0] d);
    logic [32:0] sum;
    logic [31:0] dl;
    logic [3:0] prev, t;
    if (m_state[s] != SLOT_ALLOCATED) return 1'b0;
    sum = {1'b0, d} + {1'b0, m_count};
    dl = sum[32] ? SENTINEL_DEADLINE : sum[31:0];
    m_dl[s] = dl;
    m_state[s] = SLOT_RUNNING;
    t = m_head;
    if (dl <= m_dl[t]) begin
      m_link[s] = t; m_head = s; m_next = dl;
      return 1'b1;
    end
    prev = t;
    for (int g = 0; g < 16; g++) begin
      t = m_link[prev];
      if (dl <= m_dl[t]) begin
        m_link[prev] = s; m_link[s] = t;
        return 1'b1;
      end
      prev = t;
    end
    return 1'b1;
  endfunction

  // Works out the results of one command and queues them.
  function automatic void predict_command(timer_cmd_t c);
    timer_result_t r [$];
    logic ts;
    logic [3:0] t;
    int found;
    ts = 0;
    if (c.op == OP_TICK) begin
      if (m_count < 32'hffff_fffe) m_count++;
      if (m_next <= m_count) begin
        t = m_head;
        for (int g = 0; g < 16 && m_dl[t] <= m_count; g++) begin
          m_state[t] = SLOT_ALLOCATED;
          if (m_task != 0 && t == m_task) ts = 1;
          else if (r.size() < 15) r.push_back(mk(KIND_EXPIRY, t, m_sink[t], m_pay[t], 1));
          t = m_link[t];
        end
        m_head = t;
        m_next = m_dl[t];
        if (ts) r.push_back(mk(KIND_TASK, m_task, 0, 0, 1));
      end
    end else if (c.op == OP_ALLOC) begin
      found = -1;
      for (int i = 0; i < 16; i++)
        if (found < 0 && m_state[i] == SLOT_FREE) found = i;
      if (found >= 0) m_state[found] = SLOT_ALLOCATED;
      r.push_back(mk(KIND_ALLOC, found >= 0 ? found[3:0] : 4'd0, 0, 0, found >= 0));
    end else if (c.op == OP_BIND) begin
      m_sink[c.slot] = c.sink; m_pay[c.slot] = c.pay; m_bound[c.slot] = 1;
      r.push_back(mk(KIND_STATUS, c.slot, 0, 0, 1));
    end else if (c.op == OP_ARM) begin
      r.push_back(mk(KIND_STATUS, c.slot, 0, 0, arm_timer(c.slot, c.delay)));
    end else if (c.op == OP_FREE) begin
      if (m_state[c.slot] != SLOT_RUNNING) begin
        m_state[c.slot] = SLOT_FREE;
        r.push_back(mk(KIND_STATUS, c.slot, 0, 0, 1));
      end else begin
        r.push_back(mk(KIND_STATUS, c.slot, 0, 0, 0));
      end
    end else begin
      r.push_back(mk(KIND_STATUS, c.slot, 0, 0, 0));
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[i]) pending_results.push_back(r[i]);
  endfunction

  // The request stays valid after acceptance until a gap or a pause drops it.
  task automatic gap(int maxlong);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, maxlong) : $urandom_range(0, 2);
    if (n > 0) in_chan.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_command(timer_cmd_t c);
    in_chan.valid <= 1'b1;
    in_chan.op <= c.op; in_chan.timer_slot <= c.slot; in_chan.delay <= c.delay;
    in_chan.sink_id <= c.sink; in_chan.payload <= c.pay;
    do @(posedge clk); while (!in_chan.ready);
    predict_command(c);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_task_slot(logic [3:0] v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_task = v;
  endtask

  // Makes each arm safe: an arm of an allocated slot that is not bound becomes a bind.
  function automatic timer_cmd_t random_command();
    timer_cmd_t c;
    int sel;
    c.slot = 4'($urandom_range(0, 15));
    c.delay = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
    c.sink = 8'($urandom); c.pay = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 22) c.op = OP_TICK;
    else if (sel < 40) c.op = OP_ALLOC;
    else if (sel < 58) c.op = OP_BIND;
    else if (sel < 82) c.op = OP_ARM;
    else if (sel < 96) c.op = OP_FREE;
    else c.op = 3'($urandom_range(5, 7));
    if (c.op == OP_ARM && m_state[c.slot] == SLOT_ALLOCATED && !m_bound[c.slot])
      c.op = OP_BIND;
    return c;
  endfunction

  // Result side: random stalls, one long hold-off, and the comparison.
  initial begin
    timer_result_t exp_r, got;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.kind, out_chan.slot_out, out_chan.sink_out,
               out_chan.payload_out, out_chan.ok, out_chan.last};
        results_seen++;
        if (got.kind == KIND_EXPIRY) expiries_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected no result, got %s", fmt(got));
        end else begin
          exp_r = pending_results.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected %s, got %s", fmt(exp_r), fmt(got));
          end
        end
      end
      if (hold_off) begin
        out_chan.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    timer_cmd_t dir [] ;
    timer_result_t typed [];
    timer_result_t model_r;
    timer_cmd_t c;
    in_chan.valid = 1'b0; in_chan.op = '0; in_chan.timer_slot = '0;
    in_chan.delay = '0; in_chan.sink_id = '0; in_chan.payload = '0;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed expectations for the status rows and the first allocate.
    dir = '{
      '{OP_TICK, 0, 0, 0, 0},            // tick without expiry
      '{OP_ARM, 0, 5, 0, 0},             // arm the sentinel
      '{OP_FREE, 0, 0, 0, 0},            // free the sentinel
      '{OP_ARM, 7, 5, 0, 0},             // arm a free slot
      '{OP_FREE, 9, 0, 0, 0},            // free a free slot
      '{3'd5, 15, 0, 0, 0}, '{3'd7, 3, 0, 0, 0},
      '{OP_ALLOC, 0, 0, 0, 0}, '{OP_ALLOC, 0, 0, 0, 0}, '{OP_ALLOC, 0, 0, 0, 0},
      '{OP_BIND, 1, 0, 8'hff, 8'h00}, '{OP_BIND, 2, 0, 8'h00, 8'hff},
      '{OP_BIND, 3, 0, 8'h5a, 8'ha5},
      '{OP_ARM, 1, 2, 0, 0}, '{OP_ARM, 2, 2, 0, 0},  // equal deadlines
      '{OP_ARM, 3, 32'hffff_ffff, 0, 0},              // saturated deadline
      '{OP_ARM, 1, 1, 0, 0},             // re-arm a running timer
      '{OP_FREE, 2, 0, 0, 0},            // free a running timer
      '{OP_TICK, 0, 0, 0, 0}, '{OP_TICK, 0, 0, 0, 0},
      '{OP_ARM, 1, 0, 0, 0}, '{OP_TICK, 0, 0, 0, 0}
    };
    typed = '{mk(KIND_STATUS, 0, 0, 0, 0), mk(KIND_STATUS, 0, 0, 0, 0),
              mk(KIND_STATUS, 7, 0, 0, 0), mk(KIND_STATUS, 9, 0, 0, 1),
              mk(KIND_STATUS, 15, 0, 0, 0), mk(KIND_STATUS, 3, 0, 0, 0),
              mk(KIND_ALLOC, 1, 0, 0, 1)};
    foreach (dir[i]) begin
      send_command(dir[i]);
      if (i >= 1 && i <= 7) begin
        typed[i-1].last = 1'b1;
        model_r = pending_results[$];
        if (model_r !== typed[i-1]) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch in row %0d: expected %s, model gives %s", i,
                     fmt(typed[i-1]), fmt(model_r));
        end
      end
      gap(12);
    end
    wait_drained();

    // Random phases under several task timer settings, extremes included.
    for (int phase = 0; phase < 4; phase++) begin
      write_task_slot(phase == 0 ? 4'd15 : phase == 1 ? 4'd0 :
                      phase == 2 ? 4'd1 : 4'($urandom_range(2, 14)));
      for (int n = 0; n < 18; n++) begin
        if (phase == 1 && n == 5) hold_off = 1'b1;
        if (phase == 2 && n == 15) wait_drained();
        c = random_command();
        send_command(c);
        if (!(phase == 1 && n < 15)) gap(30);
      end
      // Let the counter run into the armed deadlines.
      for (int n = 0; n < 4; n++) begin
        c = '{OP_TICK, 0, 0, 0, 0};
        send_command(c);
      end
      wait_drained();
    end

    $display("Covered %0d result requests, %0d timer expiries, four task timer settings.",
             results_seen, expiries_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
